>>> hw/rtl/dmwc_pkg.sv
// Shared types, codes and constants of the dual multiply-with-carry generator.
package dmwc_pkg;

   typedef logic [1:0]  cmd_type;
   typedef logic [15:0] half_type;
   typedef logic [31:0] word_type;

   localparam cmd_type CMD_RESEED = 2'd0;
   localparam cmd_type CMD_RAW    = 2'd1;
   localparam cmd_type CMD_RANGE  = 2'd2;

   localparam word_type SEED_LOW_BASE  = 32'hFACE1234;
   localparam word_type SEED_HIGH_BASE = 32'hBABEACED;
   localparam half_type MUL_HIGH       = 16'd36969;
   localparam half_type MUL_LOW        = 16'd18000;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_HIGH  = 7'b0000010,
      ST_LOW   = 7'b0000100,
      ST_WORD  = 7'b0001000,
      ST_RANGE = 7'b0010000,
      ST_SCALE = 7'b0100000,
      ST_PUSH  = 7'b1000000
   } state_type;

   function automatic half_type byte_swap(input half_type s);
      byte_swap = {s[7:0], s[15:8]};
   endfunction

endpackage

>>> hw/rtl/dmwc_if.sv
// Handshake channel interfaces: command request, result response and seed write.
interface dmwc_req_if;
   logic               valid;
   logic               ready;
   dmwc_pkg::cmd_type  cmd;
   dmwc_pkg::half_type range_limit;

   modport source (output valid, output cmd, output range_limit, input ready);
   modport sink   (input valid, input cmd, input range_limit, output ready);
endinterface

interface dmwc_rsp_if;
   logic               valid;
   logic               ready;
   dmwc_pkg::word_type value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface dmwc_csr_if;
   logic               valid;
   logic               ready;
   dmwc_pkg::half_type seed_word;

   modport source (output valid, output seed_word, input ready);
   modport sink   (input valid, input seed_word, output ready);
endinterface

>>> hw/rtl/dual_mwc_random_generator_unit.sv
// Top level: dual multiply-with-carry generator on one shared 16x16 multiplier.
//
//  channel   dir  payload                 role
//  req_chan  in   cmd[1:0], range_limit   reseed / raw draw / ranged draw
//  rsp_chan  out  value[31:0]             draw result (none for reseed)
//  csr_chan  in   seed_word[15:0]         seed register write, always ready
//
// A raw draw runs HIGH, LOW, WORD, PUSH; a ranged draw adds RANGE and SCALE:
// the single multiplier runs high step, low step and the range scale in turn.
// Reseed and the unused command give no result; only IDLE takes a request.
// Synchronous active-high reset loads the states as a reseed with seed zero.
// A result waits in the output register; a draw finishing behind it holds.
module dual_mwc_random_generator_unit (
   input  logic             clock,
   input  logic             reset,
   dmwc_req_if.sink         req_chan,
   dmwc_rsp_if.source       rsp_chan,
   dmwc_csr_if.sink         csr_chan
);
   import dmwc_pkg::*;

   state_type state_ff, state_in;
   word_type  gen_high_ff, gen_high_in;
   word_type  gen_low_ff, gen_low_in;
   half_type  seed_ff, seed_in;
   cmd_type   cmd_ff, cmd_in;
   half_type  range_ff, range_in;
   word_type  prod_ff, prod_in;
   half_type  fold_ff, fold_in;
   word_type  res_ff, res_in;
   logic      rsp_valid_ff, rsp_valid_in;
   word_type  rsp_value_ff, rsp_value_in;

   half_type  mul_a, mul_b;
   word_type  draw_word;
   logic      req_xfer;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.value = rsp_value_ff;

   always_comb begin
      case (state_ff)
         ST_HIGH: begin
            mul_a = gen_high_ff[15:0];
            mul_b = MUL_HIGH;
         end
         ST_LOW: begin
            mul_a = gen_low_ff[15:0];
            mul_b = MUL_LOW;
         end
         default: begin
            mul_a = fold_ff;
            mul_b = range_ff;
         end
      endcase
   end

   assign draw_word = {gen_high_ff[15:0], 16'd0} + gen_low_in;

   always_comb begin
      state_in     = state_ff;
      gen_high_in  = gen_high_ff;
      gen_low_in   = gen_low_ff;
      seed_in      = seed_ff;
      cmd_in       = cmd_ff;
      range_in     = range_ff;
      prod_in      = word_type'(mul_a) * word_type'(mul_b);
      fold_in      = fold_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;

      if (csr_chan.valid) begin
         seed_in = csr_chan.seed_word;
      end
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cmd_in   = req_chan.cmd;
               range_in = req_chan.range_limit;
               case (req_chan.cmd)
                  CMD_RESEED: begin
                     gen_low_in  = SEED_LOW_BASE ^ {16'd0, seed_ff};
                     gen_high_in = SEED_HIGH_BASE ^ {16'd0, byte_swap(seed_ff)};
                  end
                  CMD_RAW, CMD_RANGE: state_in = ST_HIGH;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_HIGH: state_in = ST_LOW;
         ST_LOW: begin
            gen_high_in = prod_ff + {16'd0, gen_high_ff[31:16]};
            state_in    = ST_WORD;
         end
         ST_WORD: begin
            gen_low_in = prod_ff + {16'd0, gen_low_ff[31:16]};
            res_in     = draw_word;
            fold_in    = draw_word[31:16] ^ draw_word[15:0];
            state_in   = (cmd_ff == CMD_RANGE) ? ST_RANGE : ST_PUSH;
         end
         ST_RANGE: state_in = ST_SCALE;
         ST_SCALE: begin
            res_in   = {16'd0, prod_ff[31:16]};
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gen_high_ff  <= SEED_HIGH_BASE;
         gen_low_ff   <= SEED_LOW_BASE;
         seed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_high_ff  <= gen_high_in;
         gen_low_ff   <= gen_low_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      range_ff     <= range_in;
      prod_ff      <= prod_in;
      fold_ff      <= fold_in;
      res_ff       <= res_in;
      rsp_value_ff <= rsp_value_in;
   end

endmodule

>>> dv/tb_top.sv
// Testbench for the dual multiply-with-carry generator: draws predicted and checked in order.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dmwc_pkg::*;

   localparam cmd_type CMD_UNUSED     = 2'd3;
   localparam int      WATCHDOG_LIMIT = 1000;
   localparam int      SETTLE_CYCLES  = 12;
   localparam int      PHASE_ITEMS    = 100;

   logic clock = 1'b0;
   logic reset;

   dmwc_req_if req_bus ();
   dmwc_rsp_if rsp_bus ();
   dmwc_csr_if csr_bus ();

   dual_mwc_random_generator_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   int       fail_count = 0;
   bit       idle_on    = 1'b1;
   int       sink_hold  = 0;
   half_type seed_reg;
   word_type mwc_high;
   word_type mwc_low;
   word_type pending_values[$];

   always #5ns clock = ~clock;

   task automatic load_generators();
      mwc_low  = SEED_LOW_BASE ^ {16'h0000, seed_reg};
      mwc_high = SEED_HIGH_BASE ^ {16'h0000, seed_reg[7:0], seed_reg[15:8]};
   endtask

   task automatic step_generators(output word_type word);
      mwc_high = word_type'(MUL_HIGH) * word_type'(mwc_high[15:0]) + word_type'(mwc_high[31:16]);
      mwc_low  = word_type'(MUL_LOW) * word_type'(mwc_low[15:0]) + word_type'(mwc_low[31:16]);
      word     = (mwc_high << 16) + mwc_low;
   endtask

   task automatic predict_command(input cmd_type cmd, input half_type range_limit);
      word_type word;
      word_type folded;
      case (cmd)
         CMD_RESEED: load_generators();
         CMD_RAW: begin
            step_generators(word);
            pending_values.push_back(word);
         end
         CMD_RANGE: begin
            step_generators(word);
            folded = word ^ (word << 16);
            pending_values.push_back((word_type'(folded[31:16]) * word_type'(range_limit)) >> 16);
         end
         default: ;
      endcase
   endtask

   task automatic issue_command(input cmd_type cmd, input half_type range_limit);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.cmd         <= cmd;
      req_bus.range_limit <= range_limit;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_command(cmd, range_limit);
   endtask

   // drop valid, wait for every pending result, then let the block settle
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_values.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(input half_type seed);
      csr_bus.valid     <= 1'b1;
      csr_bus.seed_word <= seed;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      seed_reg = seed;
   endtask

   function automatic half_type pick_range();
      case ($urandom_range(0, 3))
         0: pick_range = half_type'($urandom_range(0, 16));
         1: begin
            case ($urandom_range(0, 3))
               0: pick_range = 16'h0000;
               1: pick_range = 16'hFFFF;
               2: pick_range = 16'h0001;
               default: pick_range = 16'h8000;
            endcase
         end
         default: pick_range = half_type'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic issue_random_command();
      int       pick;
      cmd_type  cmd;
      pick = $urandom_range(0, 99);
      if (pick < 8) cmd = CMD_RESEED;
      else if (pick < 11) cmd = CMD_UNUSED;
      else if (pick < 55) cmd = CMD_RAW;
      else cmd = CMD_RANGE;
      issue_command(cmd, pick_range());
   endtask

   task automatic test_reset_state();
      issue_command(CMD_RAW, 16'h0000);
      issue_command(CMD_RANGE, 16'hFFFF);
      issue_command(CMD_RANGE, 16'h0000);
      issue_command(CMD_RANGE, 16'h0001);
      issue_command(CMD_UNUSED, 16'hFFFF);
      issue_command(CMD_RAW, 16'hFFFF);
      issue_command(CMD_RESEED, 16'h0000);
      issue_command(CMD_RAW, 16'h0000);
   endtask

   task automatic test_seed_extremes();
      wait_idle();
      write_seed(16'hFFFF);
      issue_command(CMD_RESEED, 16'hFFFF);
      issue_command(CMD_RAW, 16'h0000);
      issue_command(CMD_RANGE, 16'h8000);
      wait_idle();
      write_seed(16'h00FF);
      issue_command(CMD_RESEED, 16'h0000);
      issue_command(CMD_RANGE, 16'hFFFF);
      issue_command(CMD_RAW, 16'h5555);
      issue_command(CMD_RESEED, 16'hAAAA);
      issue_command(CMD_RAW, 16'h0000);
      wait_idle();
      write_seed(16'h0000);
      issue_command(CMD_RESEED, 16'h0000);
      issue_command(CMD_RAW, 16'h0000);
   endtask

   // receiver holds off while draws keep coming, so the input stalls
   task automatic test_output_stall();
      wait_idle();
      idle_on   = 1'b0;
      sink_hold = 80;
      repeat (16) issue_command($urandom_range(0, 1) ? CMD_RAW : CMD_RANGE, pick_range());
      idle_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 7; phase++) begin
         wait_idle();
         case (phase)
            0: write_seed(16'hFFFF);
            1: write_seed(16'h0000);
            default: write_seed(half_type'($urandom_range(0, 65535)));
         endcase
         if (phase == 6) idle_on = 1'b0;
         repeat (PHASE_ITEMS) issue_random_command();
      end
   endtask

   initial begin
      int n;
      forever begin
         if (sink_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            n = sink_hold;
            sink_hold = 0;
            repeat (n) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : check_results
      word_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_values.size() == 0) begin
            $error("value: no result expected, actual %h", rsp_bus.value);
            fail_count++;
         end else begin
            want = pending_values.pop_front();
            if (rsp_bus.value !== want) begin
               $error("value: expected %h, actual %h", want, rsp_bus.value);
               fail_count++;
            end
         end
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
             (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $error("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.cmd         <= CMD_RESEED;
      req_bus.range_limit <= 16'h0000;
      csr_bus.valid       <= 1'b0;
      csr_bus.seed_word   <= 16'h0000;
      seed_reg = 16'h0000;
      load_generators();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_seed_extremes();
      test_output_stall();
      test_random_traffic();
      wait_idle();
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
